FILE: rtl/page_free_list_allocator_assert.svh
// Assertion macros for the page free list allocator checker.
// No dependencies; included by the checker file.
`ifndef PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH

// checked only outside reset
`define PFLA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// checked on every edge, reset included
`define PFLA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

FILE: rtl/pfla_pkg.sv
// Shared types and constants for the page free list allocator.
// No dependencies.
package pfla_pkg;

    localparam int ADDR_BITS   = 34;
    localparam int PAGE_SHIFT  = 12;
    localparam int SUPER_SHIFT = 21;
    localparam int PAGE_SLOTS  = 32768;
    localparam int SUPER_SLOTS = 8;

    localparam int PAGE_NUM_W  = ADDR_BITS - PAGE_SHIFT;
    localparam int SUPER_NUM_W = ADDR_BITS - SUPER_SHIFT;
    localparam int PAGE_CNT_W  = $clog2(PAGE_SLOTS + 1);
    localparam int SUPER_CNT_W = $clog2(SUPER_SLOTS + 1);
    localparam int PAGE_IDX_W  = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int SUPER_IDX_W = (SUPER_SLOTS > 1) ? $clog2(SUPER_SLOTS) : 1;

    localparam logic [PAGE_CNT_W-1:0]  PAGE_CNT_MAX  = PAGE_CNT_W'(PAGE_SLOTS);
    localparam logic [SUPER_CNT_W-1:0] SUPER_CNT_MAX = SUPER_CNT_W'(SUPER_SLOTS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ADDR_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPERPOOL_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPERPOOL_END  = 2'd3;

    localparam logic [ADDR_BITS-1:0] PHYS_TOP_RESET = ADDR_BITS'(64'h0000_0000_8800_0000);

    typedef enum logic [1:0] {
        REQ_ALLOC_PAGE  = 2'd0,
        REQ_FREE_PAGE   = 2'd1,
        REQ_ALLOC_SUPER = 2'd2,
        REQ_FREE_SUPER  = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_req_kind             req_type;
        logic [ADDR_BITS-1:0]  page_addr;
    } t_req;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  result_addr;
        t_status               status;
    } t_rsp;

endpackage

FILE: rtl/page_free_list_allocator.sv
// A free or an allocate from an empty stack gives its result in the cycle after the
// transfer; an allocate that pops a stack registers the memory read data, then the
// result from its read state, which holds off the next request. Frees and empty
// allocates take one request per cycle; a pending result that is stalled holds off
// the next request. Reset clears both stack counts and loads the range registers;
// stack memories are not cleared, since only entries below the count are ever read.
module page_free_list_allocator
    import pfla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_req                  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_rsp                  o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAGE_RD,
        S_SUPER_RD
    } t_state;

    t_state                  r_state, n_state;
    logic [PAGE_CNT_W-1:0]   r_page_cnt, n_page_cnt;
    logic [SUPER_CNT_W-1:0]  r_super_cnt, n_super_cnt;
    logic                    r_out_valid, n_out_valid;
    t_rsp                    r_out_data, n_out_data;

    logic [ADDR_BITS-1:0]    r_kernel_end, r_phys_top, r_super_base, r_super_end;

    logic [PAGE_NUM_W-1:0]   r_page_mem [PAGE_SLOTS];
    logic [SUPER_NUM_W-1:0]  r_super_mem [SUPER_SLOTS];
    logic [PAGE_NUM_W-1:0]   r_page_rd_data;
    logic [SUPER_NUM_W-1:0]  r_super_rd_data;

    logic                    w_in_xfer;
    logic [ADDR_BITS-1:0]    w_addr;
    logic                    w_page_ok, w_super_ok;
    logic [PAGE_CNT_W-1:0]   w_page_cnt_dec;
    logic [SUPER_CNT_W-1:0]  w_super_cnt_dec;
    logic                    w_page_we, w_page_re, w_super_we, w_super_re;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_addr          = i_in_data.page_addr;
    assign w_page_cnt_dec  = r_page_cnt - 1'b1;
    assign w_super_cnt_dec = r_super_cnt - 1'b1;

    assign w_page_ok  = (w_addr[PAGE_SHIFT-1:0] == '0) && (w_addr >= r_kernel_end)
                        && (w_addr < r_phys_top);
    assign w_super_ok = (w_addr[SUPER_SHIFT-1:0] == '0) && (w_addr >= r_super_base)
                        && (w_addr < r_super_end);

    always_comb begin
        n_state     = r_state;
        n_page_cnt  = r_page_cnt;
        n_super_cnt = r_super_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        w_page_we   = 1'b0;
        w_page_re   = 1'b0;
        w_super_we  = 1'b0;
        w_super_re  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_out_data.result_addr = '0;
                    n_out_data.status      = ST_OK;
                    case (i_in_data.req_type)
                        REQ_ALLOC_PAGE: begin
                            if (r_page_cnt == '0) begin
                                n_out_valid       = 1'b1;
                                n_out_data.status = ST_EMPTY;
                            end else begin
                                n_page_cnt = w_page_cnt_dec;
                                w_page_re  = 1'b1;
                                n_state    = S_PAGE_RD;
                            end
                        end
                        REQ_FREE_PAGE: begin
                            n_out_valid = 1'b1;
                            if (!w_page_ok) begin
                                n_out_data.status = ST_BAD;
                            end else if (r_page_cnt == PAGE_CNT_MAX) begin
                                n_out_data.status = ST_FULL;
                            end else begin
                                w_page_we  = 1'b1;
                                n_page_cnt = r_page_cnt + 1'b1;
                            end
                        end
                        REQ_ALLOC_SUPER: begin
                            if (r_super_cnt == '0) begin
                                n_out_valid       = 1'b1;
                                n_out_data.status = ST_EMPTY;
                            end else begin
                                n_super_cnt = w_super_cnt_dec;
                                w_super_re  = 1'b1;
                                n_state     = S_SUPER_RD;
                            end
                        end
                        REQ_FREE_SUPER: begin
                            n_out_valid = 1'b1;
                            if (!w_super_ok) begin
                                n_out_data.status = ST_BAD;
                            end else if (r_super_cnt == SUPER_CNT_MAX) begin
                                n_out_data.status = ST_FULL;
                            end else begin
                                w_super_we  = 1'b1;
                                n_super_cnt = r_super_cnt + 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid       = 1'b1;
                            n_out_data.status = ST_EMPTY;
                        end
                    endcase
                end
            end
            S_PAGE_RD: begin
                n_out_valid            = 1'b1;
                n_out_data.result_addr = {r_page_rd_data, {PAGE_SHIFT{1'b0}}};
                n_out_data.status      = ST_OK;
                n_state                = S_IDLE;
            end
            S_SUPER_RD: begin
                n_out_valid            = 1'b1;
                n_out_data.result_addr = {r_super_rd_data, {SUPER_SHIFT{1'b0}}};
                n_out_data.status      = ST_OK;
                n_state                = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_page_cnt   <= '0;
            r_super_cnt  <= '0;
            r_out_valid  <= 1'b0;
            r_kernel_end <= '0;
            r_phys_top   <= PHYS_TOP_RESET;
            r_super_base <= '0;
            r_super_end  <= '0;
        end else begin
            r_state     <= n_state;
            r_page_cnt  <= n_page_cnt;
            r_super_cnt <= n_super_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KERNEL_END:     r_kernel_end <= i_cfg_data;
                    CFG_PHYS_TOP:       r_phys_top   <= i_cfg_data;
                    CFG_SUPERPOOL_BASE: r_super_base <= i_cfg_data;
                    CFG_SUPERPOOL_END:  r_super_end  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    // page stack memory: push at count, pop reads count-1
    always_ff @(posedge i_clk) begin
        if (w_page_we) begin
            r_page_mem[r_page_cnt[PAGE_IDX_W-1:0]] <= w_addr[ADDR_BITS-1:PAGE_SHIFT];
        end
        if (w_page_re) begin
            r_page_rd_data <= r_page_mem[w_page_cnt_dec[PAGE_IDX_W-1:0]];
        end
    end

    // superpage stack memory
    always_ff @(posedge i_clk) begin
        if (w_super_we) begin
            r_super_mem[r_super_cnt[SUPER_IDX_W-1:0]] <= w_addr[ADDR_BITS-1:SUPER_SHIFT];
        end
        if (w_super_re) begin
            r_super_rd_data <= r_super_mem[w_super_cnt_dec[SUPER_IDX_W-1:0]];
        end
    end

endmodule

FILE: rtl/pfla_checker.sv
// Port-level assertions for the page free list allocator, bound to the top level.
// Depends on pfla_pkg and page_free_list_allocator_assert.svh.
`include "page_free_list_allocator_assert.svh"

module pfla_checker
    import pfla_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_rsp                  o_out_data
);

    logic w_in_xfer;
    logic w_out_held;
    logic w_rsp_ok;
    logic w_addr_zero;

    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_held  = o_out_valid && i_out_stall;
    assign w_rsp_ok    = (o_out_data.status == ST_OK);
    assign w_addr_zero = (o_out_data.result_addr == '0);

    `PFLA_ASSERT_ALWAYS(a_no_out_after_reset, i_clk, !i_rst_n |=> !o_out_valid)
    `PFLA_ASSERT(a_addr_only_on_ok, i_clk, i_rst_n, o_out_valid |-> (w_rsp_ok || w_addr_zero))
    `PFLA_ASSERT(a_xfer_makes_progress, i_clk, i_rst_n, w_in_xfer |=> (o_in_stall || o_out_valid))
    `PFLA_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_held |=> (o_out_valid && $stable(o_out_data)))

endmodule

bind page_free_list_allocator pfla_checker u_pfla_checker (.*);

FILE: tb/page_free_list_allocator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for page_free_list_allocator: directed and random page and
// superpage requests, checked against a mirror of both free stacks. Needs pfla_pkg.
module page_free_list_allocator_tb;
    import pfla_pkg::*;

    localparam int IDLE_PCT     = 31;
    localparam int PHASE_ITEMS  = 160;
    localparam int BURST_ITEMS  = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_CAP    = 40;
    localparam logic [ADDR_BITS-1:0] ADDR_MAX  = '1;
    localparam logic [ADDR_BITS-1:0] PAGE_SZ   = ADDR_BITS'(1) << PAGE_SHIFT;
    localparam logic [ADDR_BITS-1:0] SUPER_SZ  = ADDR_BITS'(1) << SUPER_SHIFT;
    localparam logic [ADDR_BITS-1:0] KEND_TYP  = ADDR_BITS'(64'h0_8020_0000);
    localparam logic [ADDR_BITS-1:0] PTOP_TYP  = ADDR_BITS'(64'h0_8800_0000);
    localparam logic [ADDR_BITS-1:0] SBASE_TYP = ADDR_BITS'(64'h1_0000_0000);
    localparam logic [ADDR_BITS-1:0] SEND_TYP  = SBASE_TYP + 16 * SUPER_SZ;

    // Mirror of the two free stacks and the range registers.
    class page_pool_mirror;
        logic [ADDR_BITS-1:0]   kernel_end, phys_top, pool_base, pool_end;
        logic [PAGE_NUM_W-1:0]  page_mem [PAGE_SLOTS];
        logic [SUPER_NUM_W-1:0] super_mem [SUPER_SLOTS];
        int                     page_count, super_count, mismatches;
        t_rsp                   due_rsp [$];

        function new();
            kernel_end  = '0;
            phys_top    = PHYS_TOP_RESET;
            pool_base   = '0;
            pool_end    = '0;
            page_count  = 0;
            super_count = 0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_KERNEL_END:     kernel_end = val;
                CFG_PHYS_TOP:       phys_top   = val;
                CFG_SUPERPOOL_BASE: pool_base  = val;
                CFG_SUPERPOOL_END:  pool_end   = val;
                default: ;
            endcase
        endfunction

        function void take_request(t_req req);
            t_rsp rsp;
            logic [ADDR_BITS-1:0] a;
            a = req.page_addr;
            rsp.result_addr = '0;
            rsp.status      = ST_OK;
            case (req.req_type)
                REQ_ALLOC_PAGE: begin
                    if (page_count == 0) begin
                        rsp.status = ST_EMPTY;
                    end else begin
                        page_count--;
                        rsp.result_addr = ADDR_BITS'(page_mem[page_count]) << PAGE_SHIFT;
                    end
                end
                REQ_FREE_PAGE: begin
                    if (a[PAGE_SHIFT-1:0] != '0 || a < kernel_end || a >= phys_top) begin
                        rsp.status = ST_BAD;
                    end else if (page_count >= PAGE_SLOTS) begin
                        rsp.status = ST_FULL;
                    end else begin
                        page_mem[page_count] = a[ADDR_BITS-1:PAGE_SHIFT];
                        page_count++;
                    end
                end
                REQ_ALLOC_SUPER: begin
                    if (super_count == 0) begin
                        rsp.status = ST_EMPTY;
                    end else begin
                        super_count--;
                        rsp.result_addr = ADDR_BITS'(super_mem[super_count]) << SUPER_SHIFT;
                    end
                end
                default: begin
                    if (a[SUPER_SHIFT-1:0] != '0 || a < pool_base || a >= pool_end) begin
                        rsp.status = ST_BAD;
                    end else if (super_count >= SUPER_SLOTS) begin
                        rsp.status = ST_FULL;
                    end else begin
                        super_mem[super_count] = a[ADDR_BITS-1:SUPER_SHIFT];
                        super_count++;
                    end
                end
            endcase
            due_rsp.push_back(rsp);
        endfunction

        task report(string what);
            if (mismatches < PRINT_CAP)
                $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endtask

        task match_response(t_rsp got);
            t_rsp want;
            if (due_rsp.size() == 0) begin
                report($sformatf("response with none pending: addr=%h status=%0d",
                                 got.result_addr, got.status));
                return;
            end
            want = due_rsp.pop_front();
            if (got.result_addr !== want.result_addr)
                report($sformatf("result_addr %h, want %h", got.result_addr, want.result_addr));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_req                  i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_rsp                  o_out_data;

    page_pool_mirror pool = new();
    bit              idle_en = 1'b1;
    bit              hold_req = 1'b0;

    page_free_list_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, or one long counted hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall = 1'b0;
                hold_req    = 1'b0;
            end else begin
                i_out_stall = idle_en && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            pool.match_response(o_out_data);
    end

    task automatic send_req(input t_req_kind kind, input logic [ADDR_BITS-1:0] addr);
        @(negedge i_clk);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_data.req_type  = kind;
        i_in_data.page_addr = addr;
        i_in_valid          = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pool.take_request(i_in_data);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        pool.set_reg(idx, val);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pool.due_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [ADDR_BITS-1:0] kend, input logic [ADDR_BITS-1:0] ptop,
                              input logic [ADDR_BITS-1:0] sbase, input logic [ADDR_BITS-1:0] send);
        settle();
        write_reg(CFG_KERNEL_END, kend);
        write_reg(CFG_PHYS_TOP, ptop);
        write_reg(CFG_SUPERPOOL_BASE, sbase);
        write_reg(CFG_SUPERPOOL_END, send);
    endtask

    // Address near or inside [lo, hi) at the given alignment; some noise and misaligned.
    function automatic logic [ADDR_BITS-1:0] pick_addr(logic [ADDR_BITS-1:0] lo,
                                                       logic [ADDR_BITS-1:0] hi, int shift);
        longint unsigned unit, first, last, span, a, r64;
        int r;
        unit  = 64'd1 << shift;
        r64   = {$urandom, $urandom};
        first = (64'(lo) + unit - 1) & ~(unit - 1);
        r     = $urandom_range(0, 99);
        if (r < 15 || first >= 64'(hi))
            return r64[ADDR_BITS-1:0];
        last = (64'(hi) - 1) & ~(unit - 1);
        span = ((last - first) >> shift) + 1;
        if (r < 30) begin
            case ($urandom_range(0, 3))
                0: a = first;
                1: a = last;
                2: a = last + unit;
                default: a = first - unit;
            endcase
        end else begin
            a = first + ((r64 % span) << shift);
        end
        if (r >= 85)
            a = a + 1 + ($urandom % (unit - 1));
        return a[ADDR_BITS-1:0];
    endfunction

    task automatic random_ops(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_req(REQ_ALLOC_PAGE, ADDR_BITS'({$urandom, $urandom}));
            else if (r < 60)
                send_req(REQ_FREE_PAGE, pick_addr(pool.kernel_end, pool.phys_top, PAGE_SHIFT));
            else if (r < 72)
                send_req(REQ_ALLOC_SUPER, ADDR_BITS'({$urandom, $urandom}));
            else
                send_req(REQ_FREE_SUPER, pick_addr(pool.pool_base, pool.pool_end, SUPER_SHIFT));
        end
    endtask

    initial begin
        logic [ADDR_BITS-1:0] ke, sb;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_KERNEL_END;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset ranges: pages in [0, PHYS_TOP_RESET), superpool empty
        send_req(REQ_ALLOC_PAGE, '0);
        send_req(REQ_ALLOC_SUPER, ADDR_MAX);
        send_req(REQ_FREE_SUPER, '0);
        send_req(REQ_FREE_PAGE, '0);
        send_req(REQ_FREE_PAGE, PHYS_TOP_RESET - PAGE_SZ);
        send_req(REQ_FREE_PAGE, PHYS_TOP_RESET);
        send_req(REQ_FREE_PAGE, ADDR_BITS'(1));
        send_req(REQ_FREE_PAGE, ADDR_MAX);
        send_req(REQ_ALLOC_PAGE, '0);
        send_req(REQ_ALLOC_PAGE, '0);
        send_req(REQ_ALLOC_PAGE, '0);

        set_window(KEND_TYP, PTOP_TYP, SBASE_TYP, SEND_TYP);
        send_req(REQ_FREE_PAGE, KEND_TYP - PAGE_SZ);
        send_req(REQ_FREE_PAGE, KEND_TYP);
        send_req(REQ_ALLOC_PAGE, '0);
        send_req(REQ_FREE_SUPER, SBASE_TYP - SUPER_SZ);
        send_req(REQ_FREE_SUPER, SBASE_TYP + PAGE_SZ);
        send_req(REQ_FREE_SUPER, SEND_TYP);
        send_req(REQ_FREE_SUPER, SEND_TYP - SUPER_SZ);
        // double free is accepted; fills the superpage stack
        repeat (SUPER_SLOTS - 1) send_req(REQ_FREE_SUPER, SBASE_TYP);
        send_req(REQ_FREE_SUPER, SBASE_TYP);
        send_req(REQ_FREE_SUPER, SBASE_TYP + 1);
        send_req(REQ_ALLOC_SUPER, '0);

        random_ops(PHASE_ITEMS);

        set_window('0, ADDR_MAX, '0, ADDR_MAX);
        hold_req = 1'b1;
        random_ops(PHASE_ITEMS);

        set_window(ADDR_MAX, '0, ADDR_MAX, '0);
        random_ops(PHASE_ITEMS);

        repeat (2) begin
            ke = ADDR_BITS'({$urandom, $urandom});
            sb = ADDR_BITS'({$urandom, $urandom});
            set_window(ke, ke + (ADDR_BITS'($urandom_range(1, 4096)) << PAGE_SHIFT),
                       sb, sb + (ADDR_BITS'($urandom_range(0, 24)) << SUPER_SHIFT));
            random_ops(PHASE_ITEMS);
        end

        // back to back with no idling on either side
        set_window('0, ADDR_MAX, '0, ADDR_MAX);
        idle_en = 1'b0;
        random_ops(BURST_ITEMS);
        repeat (3) send_req(REQ_ALLOC_PAGE, '0);
        send_req(REQ_FREE_PAGE, PAGE_SZ);
        send_req(REQ_FREE_PAGE, PAGE_SZ);
        idle_en = 1'b1;
        random_ops(40);

        settle();
        if (pool.mismatches == 0 && pool.due_rsp.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
